// ===== sv/ggc_pkg.sv =====
// Shared types and constants for the greedy graph colorer.
package ggc_pkg;
  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_RUN = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_ADD, ST_PICK, ST_ROW, ST_SCAN, ST_ASSIGN, ST_OUT
  } state_e;

  typedef struct packed {
    logic clear_step;
    logic add;
    logic add_write;
    logic run_start;
    logic pick_step;
    logic scan_start;
    logic scan_step;
    logic assign_col;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic pick_done;
    logic scan_done;
    logic rank_done;
  } sts_t;
endpackage

// ===== sv/greedy_graph_coloring.sv =====
// Top level of the greedy graph colorer.
// Input beats carry func in tuser (0 add, 1 run) and vertex and neighbor in
// tdata. After reset the block clears its adjacency and degree tables with
// tready low. An add beat reads the vertex's row and degree in its accepting
// cycle and writes them back in the next; a duplicate or out-of-range entry
// changes nothing. A run beat colors vertices 0..n-1 (n is vertex_count
// clamped to 1..MAX_VERTICES) in descending-degree order. Each rank runs a
// degree scan through the degree RAM, fetches the chosen row, runs a neighbor
// color scan through the color RAM and then assigns the color. The result
// beat sits in a one-entry output register, so adds and the next run go on
// while it waits; a run that ends while the previous result is still held
// waits until that beat leaves.
// Write vertex_count only while no beat is in flight.
module greedy_graph_coloring #(
  parameter int MAX_VERTICES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [5:0] vertex, [11:6] neighbor
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [6:0] color_count
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i
);
  import ggc_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic [6:0] cc;

  ggc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_func_i(s_axis_tuser),
    .in_ready_o(s_axis_tready), .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready), .cmd_o(cmd), .sts_i(sts)
  );

  ggc_dp #(.MaxVertices(MAX_VERTICES)) u_dp (
    .clk_i, .rst_ni, .vertex_i(s_axis_tdata[5:0]), .neighbor_i(s_axis_tdata[11:6]),
    .cfg_we_i, .cfg_wdata_i, .cmd_i(cmd), .sts_o(sts), .color_count_o(cc)
  );

  assign m_axis_tdata = {1'b0, cc};
endmodule

// ===== sv/ggc_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
module ggc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/ggc_ctrl.sv =====
// Control state machine for the greedy graph colorer.
module ggc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_func_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ggc_pkg::cmd_t  cmd_o,
  input  ggc_pkg::sts_t  sts_i
);
  import ggc_pkg::*;
  state_e state_q, state_d;
  logic out_vld_q, out_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_vld_d = out_vld_q && !out_ready_i;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_func_i == FUNC_RUN) begin
            cmd_o.run_start = 1'b1;
            state_d = ST_PICK;
          end else begin
            cmd_o.add = 1'b1;
            state_d = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        cmd_o.add_write = 1'b1;
        state_d = ST_IDLE;
      end
      ST_PICK: begin
        cmd_o.pick_step = 1'b1;
        if (sts_i.pick_done) state_d = ST_ROW;
      end
      ST_ROW: begin
        cmd_o.scan_start = 1'b1;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = ST_ASSIGN;
      end
      ST_ASSIGN: begin
        cmd_o.assign_col = 1'b1;
        state_d = sts_i.rank_done ? ST_OUT : ST_PICK;
      end
      ST_OUT: begin
        // load the result once the output register is free or emptying
        if (!out_vld_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_vld_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

// ===== sv/ggc_dp.sv =====
// Datapath: adjacency, degree and color RAMs, pick and scan counters.
module ggc_dp #(
  parameter int MaxVertices = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [5:0]    vertex_i,
  input  logic [5:0]    neighbor_i,
  input  logic          cfg_we_i,
  input  logic [6:0]    cfg_wdata_i,
  input  ggc_pkg::cmd_t cmd_i,
  output ggc_pkg::sts_t sts_o,
  output logic [6:0]    color_count_o
);
  import ggc_pkg::*;
  localparam int Iw = $clog2(MaxVertices);
  localparam int Cw = $clog2(MaxVertices + 1);

  logic [MaxVertices-1:0] adj_rd, adj_wdata;
  logic [Iw-1:0] adj_raddr, deg_raddr, wr_addr;
  logic [Cw-1:0] deg_rd, deg_wdata;
  logic tbl_we;
  logic [MaxVertices-1:0] mask_q, used_q;
  logic [6:0] vcount_q;
  logic [Cw-1:0] n_eff;
  logic [Iw-1:0] clr_q;
  logic [Iw-1:0] av_q, an_q;
  logic av_ok_q;
  logic [Cw-1:0] vidx_q;
  logic pk_vld_q;
  logic [Iw-1:0] pk_idx_q;
  logic best_vld_q;
  logic [Iw-1:0] best_q;
  logic [Cw-1:0] bestdeg_q;
  logic [Cw-1:0] ucnt_q;
  logic rd_vld_q;
  logic [Cw-1:0] rank_q;
  logic [Iw-1:0] maxc_q;
  logic [6:0] cc_q;
  logic [Iw-1:0] col_rd, cfree, ucur, vcur, vin;
  logic in_range, take_best, add_new;

  // adjacency rows, one row per vertex
  ggc_ram #(.Width(MaxVertices), .Depth(MaxVertices)) u_adj (
    .clk_i, .we_i(tbl_we), .waddr_i(wr_addr), .wdata_i(adj_wdata),
    .raddr_i(adj_raddr), .rdata_o(adj_rd)
  );

  // distinct neighbor count per vertex
  ggc_ram #(.Width(Cw), .Depth(MaxVertices)) u_deg (
    .clk_i, .we_i(tbl_we), .waddr_i(wr_addr), .wdata_i(deg_wdata),
    .raddr_i(deg_raddr), .rdata_o(deg_rd)
  );

  // color memory, read one neighbor a cycle
  ggc_ram #(.Width(Iw), .Depth(MaxVertices)) u_col (
    .clk_i, .we_i(cmd_i.assign_col), .waddr_i(best_q), .wdata_i(cfree),
    .raddr_i(ucur), .rdata_o(col_rd)
  );

  always_comb begin
    if (vcount_q == 7'd0) n_eff = Cw'(1);
    else if (int'(vcount_q) > MaxVertices) n_eff = Cw'(MaxVertices);
    else n_eff = Cw'(vcount_q);
  end

  assign in_range = (32'(vertex_i) < MaxVertices) && (32'(neighbor_i) < MaxVertices);
  assign vin = Iw'(vertex_i);
  assign ucur = ucnt_q[Iw-1:0];
  assign vcur = vidx_q[Iw-1:0];

  // the accepting cycle of an add reads the row and degree of its vertex
  assign adj_raddr = cmd_i.add ? vin : best_q;
  assign deg_raddr = cmd_i.add ? vin : vcur;

  assign add_new = av_ok_q && !adj_rd[an_q];
  assign tbl_we = cmd_i.clear_step || (cmd_i.add_write && add_new);
  assign wr_addr = cmd_i.clear_step ? clr_q : av_q;

  always_comb begin
    adj_wdata = adj_rd;
    adj_wdata[an_q] = 1'b1;
    deg_wdata = deg_rd + 1'b1;
    if (cmd_i.clear_step) begin
      adj_wdata = '0;
      deg_wdata = '0;
    end
  end

  assign take_best = pk_vld_q && !mask_q[pk_idx_q] && (!best_vld_q || deg_rd > bestdeg_q);

  // lowest color not in used, capped at n-1 (priority over at most n bits)
  always_comb begin
    cfree = Iw'(n_eff - 1'b1);
    for (int c = MaxVertices - 1; c >= 0; c--) begin
      if (!used_q[c] && (c < int'(n_eff) - 1)) cfree = Iw'(c);
    end
  end

  assign sts_o.clear_done = (clr_q == Iw'(MaxVertices - 1));
  assign sts_o.pick_done = (vidx_q >= n_eff) && !pk_vld_q;
  assign sts_o.scan_done = (ucnt_q >= n_eff) && !rd_vld_q;
  assign sts_o.rank_done = (rank_q == n_eff - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= 7'd1;
      clr_q <= '0;
      mask_q <= '0;
      pk_vld_q <= 1'b0;
      rd_vld_q <= 1'b0;
      cc_q <= '0;
    end else begin
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      if (cmd_i.clear_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.run_start) mask_q <= '0;
      if (cmd_i.assign_col) mask_q[best_q] <= 1'b1;
      pk_vld_q <= cmd_i.pick_step && (vidx_q < n_eff);
      rd_vld_q <= cmd_i.scan_step && (ucnt_q < n_eff) && adj_rd[ucur] && mask_q[ucur];
      if (cmd_i.load_out) cc_q <= 7'(maxc_q) + 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      av_q <= vin;
      an_q <= Iw'(neighbor_i);
      av_ok_q <= in_range;
    end
    if (cmd_i.run_start) begin
      rank_q <= '0;
      maxc_q <= '0;
      vidx_q <= '0;
      best_vld_q <= 1'b0;
    end
    // advance degree scan one vertex a cycle, compare in the cycle after
    if (cmd_i.pick_step) begin
      pk_idx_q <= vcur;
      if (vidx_q < n_eff) vidx_q <= vidx_q + 1'b1;
    end
    if (take_best) begin
      best_vld_q <= 1'b1;
      bestdeg_q <= deg_rd;
      best_q <= pk_idx_q;
    end
    if (cmd_i.scan_start) begin
      ucnt_q <= '0;
      used_q <= '0;
    end
    if (cmd_i.scan_step && ucnt_q < n_eff) ucnt_q <= ucnt_q + 1'b1;
    if (rd_vld_q) used_q[col_rd] <= 1'b1;
    if (cmd_i.assign_col) begin
      if (cfree > maxc_q) maxc_q <= cfree;
      rank_q <= rank_q + 1'b1;
      vidx_q <= '0;
      best_vld_q <= 1'b0;
    end
  end

  assign color_count_o = cc_q;
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the greedy graph colorer: adjacency loads and coloring runs.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ggc_pkg::*;

  localparam int NV = 64;
  localparam int CYCLE_LIMIT = 10_000_000;

  // Scoreboard: owns the predicted graph and the queue of expected color counts.
  class color_scoreboard;
    bit [NV-1:0] adj [NV];
    int unsigned deg [NV];
    bit [6:0] vcount;
    bit [6:0] pending_counts[$];
    int errors;

    function new();
      vcount = 7'd1;
      errors = 0;
      foreach (adj[i]) begin
        adj[i] = '0;
        deg[i] = 0;
      end
    endfunction

    function bit [6:0] color_graph();
      int n, best, bestdeg, c, maxc;
      bit [NV-1:0] done;
      bit [NV-1:0] used;
      int col [NV];
      n = vcount;
      if (n < 1) n = 1;
      if (n > NV) n = NV;
      done = '0;
      maxc = 0;
      for (int r = 0; r < n; r++) begin
        best = 0;
        bestdeg = -1;
        for (int v = 0; v < n; v++)
          if (!done[v] && int'(deg[v]) > bestdeg) begin
            bestdeg = deg[v];
            best = v;
          end
        used = '0;
        for (int u = 0; u < n; u++)
          if (adj[best][u] && done[u]) used[col[u]] = 1'b1;
        c = 0;
        while (c < n - 1 && used[c]) c++;
        col[best] = c;
        done[best] = 1'b1;
        if (c > maxc) maxc = c;
      end
      return 7'(maxc + 1);
    endfunction

    // Note one accepted input beat.
    function void note_input(bit func, bit [5:0] v, bit [5:0] nb);
      if (func == FUNC_ADD) begin
        if (!adj[v][nb]) begin
          adj[v][nb] = 1'b1;
          deg[v]++;
        end
      end else begin
        pending_counts.push_back(color_graph());
      end
    endfunction

    // Check one accepted result beat against the oldest prediction.
    function void check_result(bit [7:0] data);
      bit [6:0] exp_cnt;
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected result, actual %0d", $time, data[6:0]);
        errors++;
        return;
      end
      exp_cnt = pending_counts.pop_front();
      if (data[6:0] !== exp_cnt) begin
        $display("%0t: color_count expected %0d actual %0d", $time, exp_cnt, data[6:0]);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [5:0] vertex, [11:6] neighbor
  logic s_axis_tuser = 1'b0;       // func
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [6:0] color_count
  logic cfg_we_i = 1'b0;
  logic [6:0] cfg_wdata_i = '0;

  color_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holdoff_cycles = 0;
  int cycles = 0;

  always #4 clk_i = ~clk_i;

  greedy_graph_coloring u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // Receiver: stall at random; a requested hold-off keeps tready low for a counted stretch.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (holdoff_cycles > 0) begin
      holdoff_cycles <= holdoff_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("greedy_graph_coloring: mismatch");
      $finish;
    end
  end

  // Offer one beat, with random idle cycles ahead of it; hold until accepted.
  task automatic send_beat(bit func, bit [5:0] v, bit [5:0] nb);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {4'b0, nb, v};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(func, v, nb);
  endtask

  // Drop tvalid, wait for every predicted result, then let a trailing beat finish.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_counts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Write vertex_count only while the block is idle.
  task automatic write_count(bit [6:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.vcount = val;
  endtask

  // Random graph-building phase: mostly adds within the given span, runs sprinkled in.
  task automatic random_phase(int beats, int span);
    for (int i = 0; i < beats; i++) begin
      if ($urandom_range(9) == 0)
        send_beat(FUNC_RUN, 6'($urandom), 6'($urandom));
      else if ($urandom_range(9) == 0)
        send_beat(FUNC_ADD, 6'($urandom), 6'($urandom));
      else
        send_beat(FUNC_ADD, 6'($urandom_range(span - 1)), 6'($urandom_range(span - 1)));
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: run at reset count, extreme indexes, duplicate, self entry, triangle.
    send_beat(FUNC_RUN, 6'd0, 6'd0);
    write_count(7'd4);
    send_beat(FUNC_ADD, 6'd0, 6'd1);
    send_beat(FUNC_ADD, 6'd0, 6'd1);
    send_beat(FUNC_ADD, 6'd1, 6'd0);
    send_beat(FUNC_ADD, 6'd2, 6'd2);
    send_beat(FUNC_ADD, 6'd1, 6'd2);
    send_beat(FUNC_ADD, 6'd2, 6'd1);
    send_beat(FUNC_ADD, 6'd0, 6'd2);
    send_beat(FUNC_ADD, 6'd2, 6'd0);
    send_beat(FUNC_ADD, 6'd3, 6'd63);
    send_beat(FUNC_ADD, 6'd63, 6'd63);
    send_beat(FUNC_ADD, 6'd63, 6'd0);
    send_beat(FUNC_RUN, 6'd63, 6'd63);
    write_count(7'd0);
    send_beat(FUNC_RUN, 6'd0, 6'd0);
    write_count(7'd127);
    send_beat(FUNC_RUN, 6'd0, 6'd0);
    write_count(7'd64);
    send_beat(FUNC_RUN, 6'd0, 6'd0);

    // Random phases over the idling mixes and active counts.
    write_count(7'd8);
    random_phase(150, 8);
    recv_stall_pct = 46;
    write_count(7'd12);
    random_phase(150, 12);
    recv_stall_pct = 0;
    send_idle_pct = 46;
    write_count(7'd5);
    random_phase(150, 6);
    send_idle_pct = 37;
    recv_stall_pct = 37;
    write_count(7'd16);
    random_phase(150, 16);

    // Back-pressure: hold the receiver off while the sender keeps offering beats.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_count(7'd3);
    holdoff_cycles = 300;
    for (int i = 0; i < 6; i++) begin
      send_beat(FUNC_RUN, 6'($urandom), 6'($urandom));
      send_beat(FUNC_ADD, 6'($urandom_range(2)), 6'($urandom_range(2)));
    end

    // A few runs at the full count.
    write_count(7'd64);
    random_phase(120, 64);
    send_beat(FUNC_RUN, 6'd0, 6'd0);
    drain();

    if (sb.errors == 0) begin
      $display("greedy_graph_coloring: match");
    end else begin
      $display("greedy_graph_coloring: mismatch");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/ggc_pkg.sv
sv/ggc_ram.sv
sv/ggc_ctrl.sv
sv/ggc_dp.sv
sv/greedy_graph_coloring.sv
verif/tb.sv
